FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/sdtq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue package
// Types and constants shared by the timer queue modules.
// ----------------------------------------------------------------------------
package sdtq_pkg;

    localparam int DEPTH       = 16;
    localparam int HANDLE_BITS = 8;
    localparam int IDX_BITS    = $clog2(DEPTH);
    localparam int CNT_BITS    = $clog2(DEPTH + 1);

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIRE = 1'b1;

    localparam logic [1:0] KIND_ADD_OK    = 2'd0;
    localparam logic [1:0] KIND_ADD_FULL  = 2'd1;
    localparam logic [1:0] KIND_EXPIRED   = 2'd2;
    localparam logic [1:0] KIND_FIRE_DONE = 2'd3;

    typedef struct packed {
        logic                   opcode;
        logic [63:0]            deadline;
        logic [HANDLE_BITS-1:0] timer_handle;
        logic [63:0]            now;
    } t_in_item;

    typedef struct packed {
        logic [1:0]             result_kind;
        logic [HANDLE_BITS-1:0] expired_handle;
        logic [63:0]            next_deadline;
        logic                   next_valid;
        logic                   last;
    } t_out_item;

    // Command passed from the front to the back through the queue.
    typedef struct packed {
        logic                   is_fire;
        logic [63:0]            key;
        logic [HANDLE_BITS-1:0] handle;
    } t_cmd;

endpackage

FILE: rtl/core/sorted_deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue
// Keeps timers sorted by deadline and expires the due ones on request.
// ----------------------------------------------------------------------------
// An add transaction is completed by the back end in its idle state after it
// leaves the two-entry command queue; a fire transaction starts in the idle
// state, expires one due timer at a time, then finds the first entry that is not
// due and gives the final result. Output stalls hold the back end, since it
// advances only while its single output register can take a result.
module sorted_deadline_timer_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sdtq_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output sdtq_pkg::t_out_item o_data
);
    import sdtq_pkg::*;

    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_cmd;

    sdtq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_cmd_valid(w_cmd_valid),
        .i_cmd_pop  (w_cmd_pop),
        .o_cmd      (w_cmd)
    );

    sdtq_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_cmd_valid),
        .o_cmd_pop  (w_cmd_pop),
        .i_cmd      (w_cmd),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );
endmodule

FILE: rtl/core/sdtq_front.sv
// ----------------------------------------------------------------------------
// Timer queue front end
// Accepts input transactions, classifies them and queues commands.
// ----------------------------------------------------------------------------
module sdtq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sdtq_pkg::t_in_item i_data,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop,
    output sdtq_pkg::t_cmd    o_cmd
);
    import sdtq_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_push;
    t_cmd       w_cmd;

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        w_cmd.is_fire = (i_data.opcode == OP_FIRE);
        w_cmd.key     = w_cmd.is_fire ? i_data.now : i_data.deadline;
        w_cmd.handle  = i_data.timer_handle;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
        end
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_no_overfill, i_clk, i_rst_n, r_cnt == 2'd2, !w_push)
    `ASSERT_IMPL(a_pop_valid, i_clk, i_rst_n, i_cmd_pop, o_cmd_valid)
    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2)
endmodule

FILE: rtl/core/sdtq_back.sv
// ----------------------------------------------------------------------------
// Timer queue back end
// Holds the sorted entries and executes add and fire commands.
// ----------------------------------------------------------------------------
module sdtq_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    input  sdtq_pkg::t_cmd     i_cmd,
    output logic               o_valid,
    input  logic               i_stall,
    output sdtq_pkg::t_out_item o_data
);
    import sdtq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXPIRE = 3'b010,
        ST_DONE   = 3'b100
    } t_state;

    logic [63:0]            r_dl  [DEPTH];
    logic [HANDLE_BITS-1:0] r_hd  [DEPTH];
    logic [CNT_BITS-1:0]    r_count;
    t_state                 r_state;
    logic                   r_out_valid;
    t_out_item              r_out;
    logic                   w_out_free;
    logic                   w_full;
    logic [DEPTH-1:0]       w_le;
    logic                   w_due;
    logic                   w_emit;
    t_out_item              w_final;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_full     = (r_count == CNT_BITS'(DEPTH));
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign w_due      = (r_count != '0) && (r_dl[0] < i_cmd.key);
    assign o_cmd_pop  = w_out_free && i_cmd_valid &&
                        ((r_state == ST_IDLE && !i_cmd.is_fire) || r_state == ST_DONE);
    assign w_emit     = w_out_free && i_cmd_valid &&
                        ((r_state == ST_IDLE && !i_cmd.is_fire) ||
                         (r_state == ST_EXPIRE && w_due) || r_state == ST_DONE);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_le[i] = (CNT_BITS'(i) < r_count) && (r_dl[i] <= i_cmd.key);
        end
        w_final.result_kind    = KIND_FIRE_DONE;
        w_final.expired_handle = '0;
        w_final.next_valid     = (r_count != '0);
        w_final.next_deadline  = w_final.next_valid ? r_dl[0] : 64'd0;
        w_final.last           = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_out_free && i_cmd_valid) begin
                case (r_state)
                    ST_IDLE: begin
                        if (i_cmd.is_fire) begin
                            r_state <= ST_EXPIRE;
                        end else begin
                            r_out.expired_handle <= '0;
                            r_out.last <= 1'b1;
                            if (w_full) begin
                                r_out.result_kind   <= KIND_ADD_FULL;
                                r_out.next_valid    <= 1'b1;
                                r_out.next_deadline <= r_dl[0];
                            end else begin
                                r_out.result_kind   <= KIND_ADD_OK;
                                r_out.next_valid    <= 1'b1;
                                r_out.next_deadline <= (r_count == '0 || !w_le[0]) ?
                                                       i_cmd.key : r_dl[0];
                                r_count <= r_count + 1'b1;
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (i == 0) begin
                                        if (!w_le[0]) begin
                                            r_dl[0] <= i_cmd.key;
                                            r_hd[0] <= i_cmd.handle;
                                        end
                                    end else if (!w_le[i]) begin
                                        if (w_le[i-1]) begin
                                            r_dl[i] <= i_cmd.key;
                                            r_hd[i] <= i_cmd.handle;
                                        end else begin
                                            r_dl[i] <= r_dl[i-1];
                                            r_hd[i] <= r_hd[i-1];
                                        end
                                    end
                                end
                            end
                        end
                    end
                    ST_EXPIRE: begin
                        if (w_due) begin
                            r_out.result_kind    <= KIND_EXPIRED;
                            r_out.expired_handle <= r_hd[0];
                            r_out.next_deadline  <= 64'd0;
                            r_out.next_valid     <= 1'b0;
                            r_out.last           <= 1'b0;
                            r_count <= r_count - 1'b1;
                            for (int i = 0; i < DEPTH - 1; i++) begin
                                r_dl[i] <= r_dl[i+1];
                                r_hd[i] <= r_hd[i+1];
                            end
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                    ST_DONE: begin
                        r_out       <= w_final;
                        r_state     <= ST_IDLE;
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_BITS'(DEPTH))
    `ASSERT_NEXT(a_expire_shrinks, i_clk, i_rst_n,
        r_state == ST_EXPIRE && w_out_free && i_cmd_valid && w_due,
        r_count == $past(r_count) - 1'b1)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && i_stall,
        r_out_valid && $stable(r_out))
endmodule
